// ===== sv/b2da_pkg.sv =====
// Shared types, constants and helpers for the binary to decimal ASCII digit emitter.
`timescale 1ns / 1ps

package b2da_pkg;

	localparam int unsigned COUNT_W = 4;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned ASCII_W = 6;

	localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [ASCII_W-1:0] ASCII_NINE = 6'd57;

	typedef struct packed {
		logic [COUNT_W-1:0] digit_count;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [ASCII_W-1:0] ascii_digit;
		logic               last_digit;
	} digit_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CONV,
		BK_EMIT
	} back_state_t;

	// Queue handshake between the front and back parts.
	typedef struct packed {
		logic valid;
		logic ready;
	} q_hs_t;

	// Double-dabble correction: bump a BCD digit of five or more by three.
	function automatic logic [3:0] bcd_adj(input logic [3:0] d);
		logic [3:0] r;
		r = (d >= 4'd5) ? (d + 4'd3) : d;
		return r;
	endfunction

endpackage

// ===== sv/binary_to_decimal_ascii_digits.sv =====
// Top level of the binary to decimal ASCII digit emitter.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_valid/req_ready/req) carries a digit count and an
//   unsigned value. Result channel (digit_valid/digit_ready/digit) returns
//   one ASCII character per cycle at most, most significant first, with
//   last_digit set on the final character of each run.
//   The run spells value modulo ten to the count, padded with leading '0'.
//   A count above MAX_DIGITS is treated as MAX_DIGITS; a count of zero is
//   accepted and produces no characters.
// Flow:
//   A request enters a two-entry queue. The back part then runs the
//   shift-add-3 loop over every bit of the value and afterwards emits
//   the characters; it takes a new request only once the last character
//   of a run has been emitted, and the queue lets the next requests be
//   taken meanwhile.
// Reset:
//   arst_n clears the queue, the sequencer and the output valid at once.
// Stall:
//   When digit_ready is low the current character holds in the output
//   register, emission pauses, and requests back up into the queue until
//   req_ready drops.
module binary_to_decimal_ascii_digits import b2da_pkg::*; #(
	parameter int unsigned MAX_DIGITS = 10,
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_ready,
	input  req_t   req,
	output logic   digit_valid,
	input  logic   digit_ready,
	output digit_t digit
);

	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

	// Queue head between the two parts.
	logic                  q_valid;
	logic                  q_ready;
	logic [CNT_W-1:0]      q_count;
	logic [VALUE_BITS-1:0] q_value;

	// Classify requests and hold them until the converter is free.
	b2da_front #(
		.MAX_DIGITS (MAX_DIGITS),
		.VALUE_BITS (VALUE_BITS),
		.CNT_W      (CNT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_count   (q_count),
		.q_value   (q_value)
	);

	// Convert one queued request at a time and stream its characters.
	b2da_back #(
		.MAX_DIGITS (MAX_DIGITS),
		.VALUE_BITS (VALUE_BITS),
		.CNT_W      (CNT_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_count     (q_count),
		.q_value     (q_value),
		.digit_valid (digit_valid),
		.digit_ready (digit_ready),
		.digit       (digit)
	);

endmodule

// ===== sv/b2da_front.sv =====
// Front part: accept requests, saturate the count, mask the value, queue non-empty runs.
`timescale 1ns / 1ps

module b2da_front import b2da_pkg::*; #(
	parameter int unsigned MAX_DIGITS = 10,
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned CNT_W      = $clog2(MAX_DIGITS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  q_valid,
	input  logic                  q_ready,
	output logic [CNT_W-1:0]      q_count,
	output logic [VALUE_BITS-1:0] q_value
);

	localparam int unsigned DEPTH = 2;

	logic [CNT_W-1:0]      cnt_sat;
	logic [VALUE_BITS-1:0] val_masked;
	logic                  push;
	logic                  pop;
	q_hs_t                 hs;

	logic [CNT_W-1:0]      cnt_mem_q [DEPTH];
	logic [VALUE_BITS-1:0] val_mem_q [DEPTH];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            fill_q;

	// Saturate the count; extra characters would only be leading zeros.
	always_comb begin
		if (32'(req.digit_count) > 32'(MAX_DIGITS)) begin
			cnt_sat = CNT_W'(MAX_DIGITS);
		end else begin
			cnt_sat = CNT_W'(req.digit_count);
		end
		val_masked = VALUE_BITS'(req.value);
	end

	assign req_ready = (fill_q != 2'(DEPTH));
	// Drop zero-count requests here: they produce nothing.
	assign push      = req_valid && req_ready && (cnt_sat != '0);
	assign hs.valid  = (fill_q != 2'd0);
	assign hs.ready  = q_ready;
	assign pop       = hs.valid && hs.ready;
	assign q_valid   = hs.valid;
	assign q_count   = cnt_mem_q[rd_ptr_q];
	assign q_value   = val_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cnt_mem_q[wr_ptr_q] <= cnt_sat;
			val_mem_q[wr_ptr_q] <= val_masked;
		end
	end

endmodule

// ===== sv/b2da_back.sv =====
// Back part: shift-add-3 conversion, then character emission through an output register.
`timescale 1ns / 1ps

module b2da_back import b2da_pkg::*; #(
	parameter int unsigned MAX_DIGITS = 10,
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned CNT_W      = $clog2(MAX_DIGITS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic [CNT_W-1:0]      q_count,
	input  logic [VALUE_BITS-1:0] q_value,
	output logic                  digit_valid,
	input  logic                  digit_ready,
	output digit_t                digit
);

	localparam int unsigned BCD_W = 4 * MAX_DIGITS;
	localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int unsigned BIT_W = $clog2(VALUE_BITS);

	back_state_t state_q, state_d;

	logic                  load;
	logic                  step;
	logic                  emit;
	logic                  out_free;

	logic [VALUE_BITS-1:0] shift_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj_w;
	logic [BIT_W-1:0]      bit_cnt_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  out_valid_q;
	digit_t                out_q;

	assign out_free = !out_valid_q || digit_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		step    = 1'b0;
		emit    = 1'b0;
		q_ready = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					load    = 1'b1;
					state_d = BK_CONV;
				end
			end
			BK_CONV: begin
				step = 1'b1;
				if (bit_cnt_q == '0) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (idx_q == '0) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Correct every digit, then shift the next value bit in; the carry out of the
	// top digit drops, which keeps the result modulo ten to MAX_DIGITS.
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			bcd_adj_w[4*i +: 4] = bcd_adj(bcd_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q   <= q_value;
			bcd_q     <= '0;
			bit_cnt_q <= BIT_W'(VALUE_BITS - 1);
			cnt_q     <= q_count;
		end else if (step) begin
			shift_q   <= {shift_q[VALUE_BITS-2:0], 1'b0};
			bcd_q     <= {bcd_adj_w[BCD_W-2:0], shift_q[VALUE_BITS-1]};
			bit_cnt_q <= bit_cnt_q - 1'b1;
			if (bit_cnt_q == '0) begin
				idx_q <= IDX_W'(cnt_q - 1'b1);
			end
		end else if (emit) begin
			idx_q <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (digit_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.ascii_digit <= ASCII_ZERO + ASCII_W'(bcd_q[4*idx_q +: 4]);
			out_q.last_digit  <= (idx_q == '0);
		end
	end

	assign digit_valid = out_valid_q;
	assign digit       = out_q;

endmodule

// ===== sv/b2da_checker.sv =====
// Port-level checker for the binary to decimal ASCII digit emitter, with its bind.
`timescale 1ns / 1ps

module b2da_checker import b2da_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   req_valid,
	input logic   req_ready,
	input req_t   req,
	input logic   digit_valid,
	input logic   digit_ready,
	input digit_t digit
);

	// Hold a stalled character.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !digit_ready |=> digit_valid && $stable(digit))
		else $error("stalled character changed or dropped");

	// Every character is a decimal digit.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> (digit.ascii_digit >= ASCII_ZERO) && (digit.ascii_digit <= ASCII_NINE))
		else $error("character outside '0' to '9'");

	// Inside a run, the next character follows without a gap.
	a_run_dense: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && digit_ready && !digit.last_digit |=> digit_valid)
		else $error("gap inside a run of characters");

	// The count of an accepted request is always known.
	a_req_known: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !$isunknown(req.digit_count))
		else $error("request count unknown at accept");

endmodule

bind binary_to_decimal_ascii_digits b2da_checker u_b2da_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.req         (req),
	.digit_valid (digit_valid),
	.digit_ready (digit_ready),
	.digit       (digit)
);
